FILE: design/wbhc_pkg.sv
`default_nettype none

package wbhc_pkg;

  // Fixed field widths and configuration port geometry.
  localparam int THR_W  = 40;
  localparam int CNT_W  = 8;
  localparam int STAT_W = 32;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 64;

  // Default sector size and the fixed scale factors of the datapath.
  localparam int SECTOR_BYTES_DEF = 4096;
  localparam int MS_PER_S         = 1000;
  localparam int UTIL_SCALE       = 100;

  // Reset values of the configuration registers.
  localparam logic [THR_W-1:0] THRESHOLD_RST    = 40'd52428800;
  localparam logic [CNT_W-1:0] ENABLE_RST       = 8'd3;
  localparam logic [CNT_W-1:0] DISABLE_RST      = 8'd5;
  localparam logic [CNT_W-1:0] EXPL_DISABLE_RST = 8'd60;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [1:0] REG_ENABLE       = 2'd1;
  localparam logic [1:0] REG_DISABLE      = 2'd2;
  localparam logic [1:0] REG_EXPL_DISABLE = 2'd3;

  // Command codes of an input word.
  localparam logic [1:0] CMD_UPDATE = 2'd0;
  localparam logic [1:0] CMD_ENABLE = 2'd1;
  localparam logic [1:0] CMD_RESET  = 2'd2;

  // Event codes of a result word.
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_ON     = 2'd1;
  localparam logic [1:0] EV_REMAIN = 2'd2;
  localparam logic [1:0] EV_OFF    = 2'd3;

  // Configuration register contents as seen by the controller.
  typedef struct packed {
    logic [THR_W-1:0] bw_threshold;
    logic [CNT_W-1:0] enable_periods;
    logic [CNT_W-1:0] disable_periods;
    logic [CNT_W-1:0] explicit_disable_periods;
  } cfg_regs_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_BW_WAIT,
    ST_DECIDE,
    ST_UTIL_LOAD,
    ST_UTIL_WAIT,
    ST_UTIL_FIN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: design/write_boost_hysteresis_control_unit.sv
// Write-boost hysteresis controller. Each input word is a command: an update carries the
// sectors written and the period length in ms, and the block decides whether the write
// booster goes on or off, with separate off-hysteresis counts for automatic and explicit mode;
// every word gives exactly one result word. The bandwidth test and the utilization figure
// both run through one restoring divider that retires one quotient bit per cycle; DIV_W is
// 54 at the default 4096-byte sector. An update starts the bandwidth division, waits for
// it, takes its decision, and on a switch-off runs the utilization division as well before
// its result is loaded; enable, reset and unused commands go straight to their result.
// The input is stalled while a word is in work and is free again in the cycle after its
// result is loaded, so a new word is taken only once the last one is through. A finished
// result waits in the output register and does not hold off the next input word, though
// the result of that next word waits until the output register has been emptied.
`default_nettype none

module write_boost_hysteresis_control_unit #(
  parameter int SECTOR_BYTES = wbhc_pkg::SECTOR_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Input channel.
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_cmd,
  input  wire logic [31:0]                   in_written_sectors,
  input  wire logic [31:0]                   in_elapsed_ms,
  // Result channel.
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_booster_on,
  output logic                               out_explicit_mode,
  output logic [1:0]                         out_event_res,
  output logic [31:0]                        out_on_period_count,
  output logic [31:0]                        out_utilization_percent,
  // Configuration port.
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [wbhc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [wbhc_pkg::DATA_W-1:0]   pwdata,
  output logic [wbhc_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  // Bandwidth numerator is sectors * SECTOR_BYTES * 1000; the divider is wide enough for it
  // and for the threshold compare.
  localparam int MUL_K = SECTOR_BYTES * wbhc_pkg::MS_PER_S;
  localparam int K_W   = $clog2(MUL_K + 1);
  localparam int BW_W  = 32 + K_W;
  localparam int DIV_W = (BW_W > wbhc_pkg::THR_W) ? BW_W : wbhc_pkg::THR_W;

  wbhc_pkg::cfg_regs_t cfg;
  wbhc_pkg::state_t    state_r, state_nxt;

  logic [1:0]       cmd_r, cmd_nxt;
  logic [31:0]      sec_r, sec_nxt;
  logic [31:0]      ms_r, ms_nxt;
  logic [7:0]       over_r, over_nxt;
  logic [7:0]       under_r, under_nxt;
  logic             expl_r, expl_nxt;
  logic             dec_r, dec_nxt;
  logic [31:0]      on_r, on_nxt;
  logic [31:0]      high_r, high_nxt;
  logic [1:0]       ev_r, ev_nxt;
  logic             rep_r, rep_nxt;
  logic             rep_expl_r, rep_expl_nxt;
  logic [31:0]      rep_count_r, rep_count_nxt;
  logic [31:0]      rep_util_r, rep_util_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_on_r, out_on_nxt;
  logic             out_expl_r, out_expl_nxt;
  logic [1:0]       out_ev_r, out_ev_nxt;
  logic [31:0]      out_count_r, out_count_nxt;
  logic [31:0]      out_util_r, out_util_nxt;

  logic             in_accept;
  logic             out_free;
  logic             div_start;
  logic             div_busy;
  logic [DIV_W-1:0] div_dividend;
  logic [31:0]      div_divisor;
  logic [DIV_W-1:0] div_quot;
  logic [DIV_W-1:0] bw_prod;
  logic [DIV_W-1:0] util_prod;
  logic [31:0]      util_sat;

  logic             intensive;
  logic [7:0]       over_upd;
  logic [7:0]       under_upd;
  logic [31:0]      on_upd;
  logic [31:0]      high_upd;
  logic [1:0]       ev_upd;
  logic             target;

  function automatic logic [7:0] sat_inc8(input logic [7:0] v);
    sat_inc8 = (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    sat_inc32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  wbhc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wbhc_div #(.DIV_W(DIV_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != wbhc_pkg::ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  // Divider operands: bandwidth first, then utilization on a switch-off.
  assign bw_prod      = DIV_W'(sec_r) * DIV_W'(MUL_K);
  assign util_prod    = DIV_W'(high_r) * DIV_W'(wbhc_pkg::UTIL_SCALE);
  assign div_dividend = (state_r == wbhc_pkg::ST_UTIL_LOAD) ? util_prod : bw_prod;
  assign div_divisor  = (state_r == wbhc_pkg::ST_UTIL_LOAD) ? on_r :
                        ((ms_r == 32'd0) ? 32'd1 : ms_r);
  assign util_sat     = (div_quot[DIV_W-1:32] != '0) ? 32'hFFFF_FFFF : div_quot[31:0];

  // Hysteresis decision for one update period.
  always_comb begin
    intensive = (div_quot >= DIV_W'(cfg.bw_threshold));
    on_upd    = dec_r ? sat_inc32(on_r) : on_r;
    if (intensive) begin
      over_upd  = sat_inc8(over_r);
      under_upd = 8'd0;
      high_upd  = sat_inc32(high_r);
      ev_upd    = wbhc_pkg::EV_NONE;
    end else begin
      over_upd  = 8'd0;
      under_upd = sat_inc8(under_r);
      high_upd  = high_r;
      ev_upd    = (over_r != 8'd0 && !dec_r && !expl_r) ? wbhc_pkg::EV_REMAIN
                                                        : wbhc_pkg::EV_NONE;
    end
    target = dec_r;
    if (over_upd >= cfg.enable_periods) begin
      target = 1'b1;
    end
    if (!expl_r && under_upd >= cfg.disable_periods) begin
      target = 1'b0;
    end
    if (expl_r && under_upd >= cfg.explicit_disable_periods) begin
      target = 1'b0;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wbhc_pkg::ST_IDLE:
        if (in_accept) begin
          state_nxt = wbhc_pkg::ST_EXEC;
        end
      wbhc_pkg::ST_EXEC:
        state_nxt = (cmd_r == wbhc_pkg::CMD_UPDATE) ? wbhc_pkg::ST_BW_WAIT
                                                    : wbhc_pkg::ST_DONE;
      wbhc_pkg::ST_BW_WAIT:
        if (!div_busy) begin
          state_nxt = wbhc_pkg::ST_DECIDE;
        end
      wbhc_pkg::ST_DECIDE:
        state_nxt = (dec_r && !target) ? wbhc_pkg::ST_UTIL_LOAD : wbhc_pkg::ST_DONE;
      wbhc_pkg::ST_UTIL_LOAD:
        state_nxt = wbhc_pkg::ST_UTIL_WAIT;
      wbhc_pkg::ST_UTIL_WAIT:
        if (!div_busy) begin
          state_nxt = wbhc_pkg::ST_UTIL_FIN;
        end
      wbhc_pkg::ST_UTIL_FIN:
        state_nxt = wbhc_pkg::ST_DONE;
      wbhc_pkg::ST_DONE:
        if (out_free) begin
          state_nxt = wbhc_pkg::ST_IDLE;
        end
      default:
        state_nxt = wbhc_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs per state.
  always_comb begin
    cmd_nxt       = cmd_r;
    sec_nxt       = sec_r;
    ms_nxt        = ms_r;
    over_nxt      = over_r;
    under_nxt     = under_r;
    expl_nxt      = expl_r;
    dec_nxt       = dec_r;
    on_nxt        = on_r;
    high_nxt      = high_r;
    ev_nxt        = ev_r;
    rep_nxt       = rep_r;
    rep_expl_nxt  = rep_expl_r;
    rep_count_nxt = rep_count_r;
    rep_util_nxt  = rep_util_r;
    out_on_nxt    = out_on_r;
    out_expl_nxt  = out_expl_r;
    out_ev_nxt    = out_ev_r;
    out_count_nxt = out_count_r;
    out_util_nxt  = out_util_r;
    out_valid_nxt = out_valid_r && out_stall;
    div_start     = 1'b0;
    unique case (state_r)
      wbhc_pkg::ST_IDLE:
        if (in_accept) begin
          cmd_nxt = in_cmd;
          sec_nxt = in_written_sectors;
          ms_nxt  = in_elapsed_ms;
        end
      wbhc_pkg::ST_EXEC: begin
        ev_nxt        = wbhc_pkg::EV_NONE;
        rep_nxt       = 1'b0;
        rep_expl_nxt  = 1'b0;
        rep_count_nxt = 32'd0;
        rep_util_nxt  = 32'd0;
        unique case (cmd_r)
          wbhc_pkg::CMD_ENABLE: begin
            expl_nxt  = 1'b1;
            dec_nxt   = 1'b1;
            over_nxt  = 8'd0;
            under_nxt = 8'd0;
          end
          wbhc_pkg::CMD_RESET: begin
            expl_nxt  = 1'b0;
            dec_nxt   = 1'b0;
            over_nxt  = 8'd0;
            under_nxt = 8'd0;
          end
          wbhc_pkg::CMD_UPDATE:
            div_start = 1'b1;
          default: ;
        endcase
      end
      wbhc_pkg::ST_BW_WAIT: ;
      wbhc_pkg::ST_DECIDE: begin
        over_nxt  = over_upd;
        under_nxt = under_upd;
        on_nxt    = on_upd;
        high_nxt  = high_upd;
        ev_nxt    = ev_upd;
        if (target != dec_r) begin
          dec_nxt = target;
          if (!target) begin
            // Switch-off: the on-period count is at least one here.
            ev_nxt        = wbhc_pkg::EV_OFF;
            rep_nxt       = 1'b1;
            rep_count_nxt = on_upd;
            rep_expl_nxt  = expl_r;
            expl_nxt      = 1'b0;
          end else begin
            ev_nxt = wbhc_pkg::EV_ON;
          end
        end
      end
      wbhc_pkg::ST_UTIL_LOAD:
        div_start = 1'b1;
      wbhc_pkg::ST_UTIL_WAIT: ;
      wbhc_pkg::ST_UTIL_FIN: begin
        rep_util_nxt = util_sat;
        on_nxt       = 32'd0;
        high_nxt     = 32'd0;
      end
      wbhc_pkg::ST_DONE:
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_on_nxt    = dec_r;
          out_expl_nxt  = rep_r ? rep_expl_r : expl_r;
          out_ev_nxt    = ev_r;
          out_count_nxt = rep_count_r;
          out_util_nxt  = rep_util_r;
        end
      default: ;
    endcase
  end

  // Control and decision state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wbhc_pkg::ST_IDLE;
      over_r      <= 8'd0;
      under_r     <= 8'd0;
      expl_r      <= 1'b0;
      dec_r       <= 1'b0;
      on_r        <= 32'd0;
      high_r      <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      over_r      <= over_nxt;
      under_r     <= under_nxt;
      expl_r      <= expl_nxt;
      dec_r       <= dec_nxt;
      on_r        <= on_nxt;
      high_r      <= high_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    sec_r       <= sec_nxt;
    ms_r        <= ms_nxt;
    ev_r        <= ev_nxt;
    rep_r       <= rep_nxt;
    rep_expl_r  <= rep_expl_nxt;
    rep_count_r <= rep_count_nxt;
    rep_util_r  <= rep_util_nxt;
    out_on_r    <= out_on_nxt;
    out_expl_r  <= out_expl_nxt;
    out_ev_r    <= out_ev_nxt;
    out_count_r <= out_count_nxt;
    out_util_r  <= out_util_nxt;
  end

  assign out_valid               = out_valid_r;
  assign out_booster_on          = out_on_r;
  assign out_explicit_mode       = out_expl_r;
  assign out_event_res           = out_ev_r;
  assign out_on_period_count     = out_count_r;
  assign out_utilization_percent = out_util_r;

endmodule

`default_nettype wire

FILE: design/wbhc_div.sv
`default_nettype none

// Restoring divider that produces one quotient bit per cycle.
module wbhc_div #(
  parameter int DIV_W = 54
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [31:0]      divisor,
  output logic                  busy,
  output logic [DIV_W-1:0]      quotient
);

  localparam int STEP_W = $clog2(DIV_W + 1);

  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [31:0]       rem_r, rem_nxt;
  logic [31:0]       dsr_r, dsr_nxt;
  logic [32:0]       rem_sh;
  logic [32:0]       diff;
  logic              ge;

  // One trial subtraction of the shifted remainder.
  assign rem_sh = {rem_r, quo_r[DIV_W-1]};
  assign diff   = rem_sh - {1'b0, dsr_r};
  assign ge     = (rem_sh >= {1'b0, dsr_r});

  always_comb begin
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dsr_nxt = dsr_r;
    if (start) begin
      cnt_nxt = STEP_W'(DIV_W);
      quo_nxt = dividend;
      rem_nxt = '0;
      dsr_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - STEP_W'(1);
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      rem_nxt = ge ? diff[31:0] : rem_sh[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy     = (cnt_r != '0);
  assign quotient = quo_r;

endmodule

`default_nettype wire

FILE: design/wbhc_cfg.sv
`default_nettype none

// Configuration registers behind the APB-style port.
module wbhc_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [wbhc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [wbhc_pkg::DATA_W-1:0]   pwdata,
  output logic [wbhc_pkg::DATA_W-1:0]        prdata,
  output logic                               pready,
  output wbhc_pkg::cfg_regs_t                cfg
);

  logic [wbhc_pkg::THR_W-1:0] thr_r, thr_nxt;
  logic [wbhc_pkg::CNT_W-1:0] en_r, en_nxt;
  logic [wbhc_pkg::CNT_W-1:0] dis_r, dis_nxt;
  logic [wbhc_pkg::CNT_W-1:0] xdis_r, xdis_nxt;
  logic [1:0]                 idx;
  logic                       wr_en;

  // Registers sit on 8-byte boundaries.
  assign idx   = paddr[4:3];
  assign wr_en = psel && penable && pwrite;

  // Write decode.
  always_comb begin
    thr_nxt  = thr_r;
    en_nxt   = en_r;
    dis_nxt  = dis_r;
    xdis_nxt = xdis_r;
    if (wr_en) begin
      unique case (idx)
        wbhc_pkg::REG_THRESHOLD:    thr_nxt  = pwdata[wbhc_pkg::THR_W-1:0];
        wbhc_pkg::REG_ENABLE:       en_nxt   = pwdata[wbhc_pkg::CNT_W-1:0];
        wbhc_pkg::REG_DISABLE:      dis_nxt  = pwdata[wbhc_pkg::CNT_W-1:0];
        wbhc_pkg::REG_EXPL_DISABLE: xdis_nxt = pwdata[wbhc_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= wbhc_pkg::THRESHOLD_RST;
      en_r   <= wbhc_pkg::ENABLE_RST;
      dis_r  <= wbhc_pkg::DISABLE_RST;
      xdis_r <= wbhc_pkg::EXPL_DISABLE_RST;
    end else begin
      thr_r  <= thr_nxt;
      en_r   <= en_nxt;
      dis_r  <= dis_nxt;
      xdis_r <= xdis_nxt;
    end
  end

  // Read decode.
  always_comb begin
    unique case (idx)
      wbhc_pkg::REG_THRESHOLD:    prdata = wbhc_pkg::DATA_W'(thr_r);
      wbhc_pkg::REG_ENABLE:       prdata = wbhc_pkg::DATA_W'(en_r);
      wbhc_pkg::REG_DISABLE:      prdata = wbhc_pkg::DATA_W'(dis_r);
      wbhc_pkg::REG_EXPL_DISABLE: prdata = wbhc_pkg::DATA_W'(xdis_r);
      default:                    prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  assign cfg.bw_threshold             = thr_r;
  assign cfg.enable_periods           = en_r;
  assign cfg.disable_periods          = dis_r;
  assign cfg.explicit_disable_periods = xdis_r;

endmodule

`default_nettype wire

FILE: design/wbhc_checker.sv
`default_nettype none

// Port-level checks on the write-boost controller.
module wbhc_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic                        out_booster_on,
  input wire logic                        out_explicit_mode,
  input wire logic [1:0]                  out_event_res,
  input wire logic [31:0]                 out_on_period_count,
  input wire logic [31:0]                 out_utilization_percent
);

  // One word at a time: the input stalls right after an accepted word.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after an accepted word");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_event_res) &&
                                  $stable(out_on_period_count)))
    else $error("stalled result word changed");

  // A switch-off report always leaves the booster off.
  a_off_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_res == wbhc_pkg::EV_OFF) |-> !out_booster_on)
    else $error("switch-off event with booster on");

  // Statistics appear only with a switch-off report.
  a_stats_only_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_res != wbhc_pkg::EV_OFF) |->
      (out_on_period_count == 32'd0 && out_utilization_percent == 32'd0))
    else $error("statistics reported without a switch-off");

  // Explicit mode is only held while the booster is on.
  a_explicit_on: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_explicit_mode && out_event_res != wbhc_pkg::EV_OFF) |->
      out_booster_on)
    else $error("explicit mode with booster off");

endmodule

bind write_boost_hysteresis_control_unit wbhc_checker u_wbhc_checker (.*);

`default_nettype wire
